// ===== sv/sprite_nearest_scaler_assert.svh =====
// assertion macros for the sprite scaler checker
// used by sprite_nearest_scaler_chk.sv, needs aclk and aresetn in scope
`ifndef SPRITE_NEAREST_SCALER_ASSERT_SVH
`define SPRITE_NEAREST_SCALER_ASSERT_SVH

// a implies c on the next edge, ignored while in reset
`define SNS_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("sprite scaler check failed");

// c holds on the edge after reset was seen
`define SNS_ASSERT_AFTER_RESET(lbl, c) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (c)) \
        else $error("sprite scaler reset check failed");

`endif

// ===== sv/sns_pkg.sv =====
// shared constants and types for the sprite nearest scaler
// no dependencies
`default_nettype none

package sns_pkg;

    localparam int COORD_BITS  = 12;
    localparam int MAX_TEXELS  = 4096;
    localparam int ADDR_W      = $clog2(MAX_TEXELS);
    localparam int TEXIDX_W    = 12;
    localparam int SIZE_W      = 7;
    localparam int SPAN_W      = 12;
    localparam int COLOR_W     = 32;
    localparam int ALPHA_LSB   = 24;
    localparam int MAG_W       = COORD_BITS + 2;
    localparam int NUM_W       = MAG_W + SIZE_W;
    localparam int DIV_LAT     = 1 + 2 * NUM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRITE_WIDTH  = 3'd0,
        CFG_SPRITE_HEIGHT = 3'd1,
        CFG_SPAN_X        = 3'd2,
        CFG_SPAN_Y        = 3'd3,
        CFG_ERROR_COLOR   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        sprite_width;
        logic [SIZE_W-1:0]        sprite_height;
        logic signed [SPAN_W-1:0] span_x;
        logic signed [SPAN_W-1:0] span_y;
        logic [COLOR_W-1:0]       error_color;
    } cfg_t;

    typedef struct packed {
        logic                         is_load;
        logic [ADDR_W-1:0]            tex_addr;
        logic [COLOR_W-1:0]           tex_value;
        logic signed [COORD_BITS-1:0] pix_x;
        logic signed [COORD_BITS-1:0] pix_y;
        logic [MAG_W-1:0]             mag_x;
        logic [MAG_W-1:0]             mag_y;
        logic                         alpha_test;
    } item_t;

endpackage

`default_nettype wire

// ===== sv/sns_front.sv =====
// front end: classifies input items and forms the axis offset magnitudes
// depends on sns_pkg
`default_nettype none

module sns_front import sns_pkg::*; (
    input  logic                         action,
    input  logic [TEXIDX_W-1:0]          texel_index,
    input  logic [COLOR_W-1:0]           texel_value,
    input  logic signed [COORD_BITS-1:0] dest_x,
    input  logic signed [COORD_BITS-1:0] dest_y,
    input  logic signed [COORD_BITS-1:0] origin_x,
    input  logic signed [COORD_BITS-1:0] origin_y,
    input  logic                         mirror,
    input  logic                         alpha_test,
    input  logic signed [SPAN_W-1:0]     span_x,
    output logic                         keep,
    output item_t                        item
);

    logic signed [MAG_W-1:0] off_x;
    logic signed [MAG_W-1:0] off_y;
    logic signed [MAG_W-1:0] num_x;
    logic                    in_range;

    assign off_x    = MAG_W'(dest_x) - MAG_W'(origin_x);
    assign off_y    = MAG_W'(dest_y) - MAG_W'(origin_y);
    assign num_x    = mirror ? (MAG_W'(span_x) - off_x) : off_x;
    assign in_range = {1'b0, texel_index} < (TEXIDX_W+1)'(MAX_TEXELS);

    // out of range loads are dropped here
    assign keep = (action == ACT_SAMPLE) || in_range;

    always_comb begin
        item            = '0;
        item.is_load    = (action == ACT_LOAD);
        item.tex_addr   = ADDR_W'(texel_index);
        item.tex_value  = texel_value;
        item.pix_x      = dest_x;
        item.pix_y      = dest_y;
        item.mag_x      = num_x[MAG_W-1] ? MAG_W'(-num_x) : MAG_W'(num_x);
        item.mag_y      = off_y[MAG_W-1] ? MAG_W'(-off_y) : MAG_W'(off_y);
        item.alpha_test = alpha_test;
    end

endmodule

`default_nettype wire

// ===== sv/sns_queue.sv =====
// short queue between front and back end
// depends on sns_pkg
`default_nettype none

module sns_queue import sns_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t item_in,
    output logic  full,
    input  logic  pop,
    output item_t item_out,
    output logic  empty
);

    item_t               slot_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign item_out = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sns_axis_div.sv =====
// pipelined axis index: (mag*(n-1)/span) mod n, one quotient bit per stage
// depends on sns_pkg
`default_nettype none

module sns_axis_div import sns_pkg::*; (
    input  logic              aclk,
    input  logic              adv,
    input  logic [MAG_W-1:0]  mag_in,
    input  logic [SIZE_W-1:0] size,
    input  logic [SPAN_W-1:0] span_mag,
    output logic [SIZE_W-1:0] idx_out
);

    logic [NUM_W-1:0]  quo_reg  [0:NUM_W];
    logic [SPAN_W-1:0] rem_reg  [0:NUM_W];
    logic [NUM_W-1:0]  quo_next [1:NUM_W];
    logic [SPAN_W-1:0] rem_next [1:NUM_W];
    logic [SPAN_W:0]   dtrial   [0:NUM_W-1];
    logic              dge      [0:NUM_W-1];

    logic [NUM_W-1:0]  sh_reg   [1:NUM_W];
    logic [SIZE_W-1:0] mod_reg  [1:NUM_W];
    logic [NUM_W-1:0]  sh_cur   [0:NUM_W-1];
    logic [SIZE_W-1:0] mod_cur  [0:NUM_W-1];
    logic [NUM_W-1:0]  sh_next  [1:NUM_W];
    logic [SIZE_W-1:0] mod_next [1:NUM_W];
    logic [SIZE_W:0]   mtrial   [0:NUM_W-1];
    logic              mge      [0:NUM_W-1];

    // restoring divide by span
    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            dtrial[k]     = {rem_reg[k], quo_reg[k][NUM_W-1]};
            dge[k]        = dtrial[k] >= {1'b0, span_mag};
            rem_next[k+1] = dge[k] ? SPAN_W'(dtrial[k] - {1'b0, span_mag})
                                   : dtrial[k][SPAN_W-1:0];
            quo_next[k+1] = {quo_reg[k][NUM_W-2:0], dge[k]};
        end
    end

    // remainder of the quotient by the sprite size
    always_comb begin
        sh_cur[0]  = quo_reg[NUM_W];
        mod_cur[0] = '0;
        for (int k = 1; k < NUM_W; k++) begin
            sh_cur[k]  = sh_reg[k];
            mod_cur[k] = mod_reg[k];
        end
        for (int k = 0; k < NUM_W; k++) begin
            mtrial[k]     = {mod_cur[k], sh_cur[k][NUM_W-1]};
            mge[k]        = mtrial[k] >= {1'b0, size};
            mod_next[k+1] = mge[k] ? SIZE_W'(mtrial[k] - {1'b0, size})
                                   : mtrial[k][SIZE_W-1:0];
            sh_next[k+1]  = {sh_cur[k][NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quo_reg[0] <= NUM_W'(mag_in) * NUM_W'(SIZE_W'(size - SIZE_W'(1)));
            rem_reg[0] <= '0;
            for (int k = 1; k <= NUM_W; k++) begin
                quo_reg[k] <= quo_next[k];
                rem_reg[k] <= rem_next[k];
                sh_reg[k]  <= sh_next[k];
                mod_reg[k] <= mod_next[k];
            end
        end
    end

    assign idx_out = mod_reg[NUM_W];

endmodule

`default_nettype wire

// ===== sv/sns_back.sv =====
// back end: index pipeline, texel address, texel store and result register
// depends on sns_pkg, sns_axis_div
`default_nettype none

module sns_back import sns_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  item_t                        head,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_W-1:0]           color,
    output logic                         draw_enable
);

    logic                      adv;
    logic [SPAN_W-1:0]         span_mag_x;
    logic [SPAN_W-1:0]         span_mag_y;
    logic [SIZE_W-1:0]         idx_x;
    logic [SIZE_W-1:0]         idx_y;
    logic [SIZE_W-1:0]         col;
    logic [SIZE_W-1:0]         row;
    logic [2*SIZE_W:0]         addr_full;

    logic                      vld_reg  [0:DIV_LAT-1];
    item_t                     side_reg [0:DIV_LAT-1];

    logic                      a_vld_reg;
    item_t                     a_side_reg;
    logic [ADDR_W-1:0]         a_addr_reg;

    logic                      b_vld_reg;
    item_t                     b_side_reg;
    logic [COLOR_W-1:0]        rdata_reg;
    logic [COLOR_W-1:0]        texel_mem [0:MAX_TEXELS-1];

    logic                      empty_sprite;
    logic [COLOR_W-1:0]        color_sel;
    logic                      skip;

    logic                      out_valid_reg;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic                      draw_enable_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    assign span_mag_x = cfg.span_x[SPAN_W-1] ? SPAN_W'(-cfg.span_x) : SPAN_W'(cfg.span_x);
    assign span_mag_y = cfg.span_y[SPAN_W-1] ? SPAN_W'(-cfg.span_y) : SPAN_W'(cfg.span_y);

    sns_axis_div u_div_x (
        .aclk     (aclk),
        .adv      (adv),
        .mag_in   (head.mag_x),
        .size     (cfg.sprite_width),
        .span_mag (span_mag_x),
        .idx_out  (idx_x)
    );

    sns_axis_div u_div_y (
        .aclk     (aclk),
        .adv      (adv),
        .mag_in   (head.mag_y),
        .size     (cfg.sprite_height),
        .span_mag (span_mag_y),
        .idx_out  (idx_y)
    );

    // zero span maps the axis to index 0
    assign col       = (span_mag_x == '0) ? '0 : idx_x;
    assign row       = (span_mag_y == '0) ? '0 : idx_y;
    assign addr_full = (2*SIZE_W+1)'(row) * (2*SIZE_W+1)'(cfg.sprite_width)
                       + (2*SIZE_W+1)'(col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= q_pop;
            for (int k = 1; k < DIV_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            a_vld_reg <= vld_reg[DIV_LAT-1];
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= head;
            for (int k = 1; k < DIV_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            a_side_reg <= side_reg[DIV_LAT-1];
            a_addr_reg <= side_reg[DIV_LAT-1].is_load ? side_reg[DIV_LAT-1].tex_addr
                                                      : ADDR_W'(addr_full);
            b_side_reg <= a_side_reg;
        end
    end

    // loads write at the same stage samples read, so order is kept
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (a_vld_reg && a_side_reg.is_load) begin
                texel_mem[a_addr_reg] <= a_side_reg.tex_value;
            end
            rdata_reg <= texel_mem[a_addr_reg];
        end
    end

    assign empty_sprite = (cfg.sprite_width == '0) || (cfg.sprite_height == '0);
    assign color_sel    = empty_sprite ? cfg.error_color : rdata_reg;
    assign skip         = b_side_reg.alpha_test
                          && ((color_sel == cfg.error_color)
                              || (color_sel[COLOR_W-1:ALPHA_LSB] == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= b_vld_reg && !b_side_reg.is_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pixel_x_reg     <= b_side_reg.pix_x;
            pixel_y_reg     <= b_side_reg.pix_y;
            color_reg       <= color_sel;
            draw_enable_reg <= !skip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign color       = color_reg;
    assign draw_enable = draw_enable_reg;

endmodule

`default_nettype wire

// ===== sv/sprite_nearest_scaler.sv =====
// top level of the nearest neighbor sprite scaler: config registers, front, queue, back
// depends on sns_pkg, sns_front, sns_queue, sns_back
//
// channel  | dir | handshake             | payload
// s_       | in  | s_tvalid / s_tready   | tuser action, tdata load or sample request
// m_       | out | m_tvalid / m_tready   | tuser draw_enable, tdata pixel and color
// cfg_     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request per cycle sustained while m_tready keeps up; a sample passes the queue,
// the two bit-per-stage divide and modulo pipelines, texel store and result register
// loads give no result; they write the texel store in order with samples
// a stalled m_ side freezes the back end, the queue then fills and drops s_tready
// reset is synchronous, active low; the texel store is not cleared
`default_nettype none

module sprite_nearest_scaler import sns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // texel_index, texel_value, dest_x, dest_y,
                                            // origin_x, origin_y, mirror, alpha_test
    input  logic [0:0]           s_tuser,   // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // pixel_x, pixel_y, color
    output logic [0:0]           m_tuser,   // draw_enable
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t                         cfg_reg;
    item_t                        f_item;
    item_t                        q_head;
    logic                         f_keep;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]           color;
    logic                         draw_enable;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_data[SIZE_W-1:0];
                CFG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_data[SIZE_W-1:0];
                CFG_SPAN_X:        cfg_reg.span_x        <= cfg_data[SPAN_W-1:0];
                CFG_SPAN_Y:        cfg_reg.span_y        <= cfg_data[SPAN_W-1:0];
                CFG_ERROR_COLOR:   cfg_reg.error_color   <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    sns_front u_front (
        .action      (s_tuser[0]),
        .texel_index (s_tdata[11:0]),
        .texel_value (s_tdata[43:12]),
        .dest_x      (s_tdata[55:44]),
        .dest_y      (s_tdata[67:56]),
        .origin_x    (s_tdata[79:68]),
        .origin_y    (s_tdata[91:80]),
        .mirror      (s_tdata[92]),
        .alpha_test  (s_tdata[93]),
        .span_x      (cfg_reg.span_x),
        .keep        (f_keep),
        .item        (f_item)
    );

    assign s_tready = !q_full;

    sns_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_tvalid && s_tready && f_keep),
        .item_in  (f_item),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_head),
        .empty    (q_empty)
    );

    sns_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color       (color),
        .draw_enable (draw_enable)
    );

    assign m_tdata = {color, pixel_y, pixel_x};
    assign m_tuser = draw_enable;

endmodule

`default_nettype wire

// ===== sv/sprite_nearest_scaler_chk.sv =====
// port level checker for sprite_nearest_scaler, bound to the top level
// depends on sprite_nearest_scaler_assert.svh
`default_nettype none
`include "sprite_nearest_scaler_assert.svh"

module sprite_nearest_scaler_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `SNS_ASSERT_AFTER_RESET(a_no_result_after_reset, !m_tvalid)
    `SNS_ASSERT_AFTER_RESET(a_ready_after_reset, s_tready)
    `SNS_ASSERT_NEXT(a_stalled_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind sprite_nearest_scaler sprite_nearest_scaler_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
